// ===== rtl/yt_pkg.sv =====
`timescale 1ns / 1ps

package yt_pkg;

  // Store geometry
  localparam int ROWS       = 4;
  localparam int COLS       = 4;
  localparam int VALUE_BITS = 20;
  localparam int CELLS      = ROWS * COLS;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DIMR_W = $clog2(ROWS + 1);
  localparam int DIMC_W = $clog2(COLS + 1);

  // Fixed port widths
  localparam int ACT_W   = 2;
  localparam int RC_W    = 2;
  localparam int VALUE_W = 20;
  localparam int CFG_W   = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [DIMR_W-1:0]     dimr_t;
  typedef logic [DIMC_W-1:0]     dimc_t;

  localparam value_t EMPTY_CELL = value_t'(1000000);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXTRACT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

  // Store access: one write port, two read ports
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    addr_t  raddr0;
    addr_t  raddr1;
  } st_req_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value_out;
    logic               found;
    logic               was_empty;
  } res_t;

  function automatic addr_t cell_addr(row_t r, col_t c);
    return addr_t'(int'(r) * COLS + int'(c));
  endfunction

endpackage

// ===== rtl/young_tableau_extract_and_search.sv =====
`timescale 1ns / 1ps

// Young tableau (row- and column-sorted 4x4 matrix) with cell write, minimum
// extract and key search. Pulse start while busy is low to issue one command;
// every command yields exactly one result beat, shown for a single cycle with
// out_valid high. The receiver cannot stall, so sample the beat when it shows.
// An extract sifts the moved value down for k steps, with k at most
// rows_used + cols_used - 2, and ends when the value reaches the last used
// corner or when a compare stops it. A search visits at most rows_used +
// cols_used - 1 cells and stops at the first match. Each step is one read of
// the cell store plus one compare/write-back. A new command may start the cycle
// after busy drops. All cells read as the empty sentinel 1000000 after reset
// with no clearing pass. rows_used/cols_used of 0 act as 1, above 4 as 4;
// write them only while idle.

module young_tableau_extract_and_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [yt_pkg::ACT_W-1:0]          in_action,
  input  logic [yt_pkg::RC_W-1:0]           in_row,
  input  logic [yt_pkg::RC_W-1:0]           in_col,
  input  logic [yt_pkg::VALUE_W-1:0]        in_value,
  output logic                              out_valid,
  output logic [yt_pkg::VALUE_W-1:0]        out_value_out,
  output logic                              out_found,
  output logic                              out_was_empty,
  input  logic                              cfg_we,
  input  logic [yt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [yt_pkg::CFG_W-1:0]          cfg_data
);
  import yt_pkg::*;

  logic [CFG_W-1:0] rows_used_r;
  logic [CFG_W-1:0] cols_used_r;
  st_req_t          st_req;
  value_t           rd0, rd1;
  res_t             res;

  // Used-size registers; clamping happens at command accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= CFG_W'(4);
      cols_used_r <= CFG_W'(4);
    end else if (cfg_we) begin
      priority if (cfg_index == CFG_ROWS_USED) begin
        rows_used_r <= cfg_data;
      end else if (cfg_index == CFG_COLS_USED) begin
        cols_used_r <= cfg_data;
      end
    end
  end

  // Sequencer: walks the sift-down / search path one cell per step
  yt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .rows_used (rows_used_r),
    .cols_used (cols_used_r),
    .busy      (busy),
    .res       (res),
    .st_req    (st_req),
    .rd0       (rd0),
    .rd1       (rd1)
  );

  // Cell store: 1 write, 2 reads (right and down neighbor in a sift) per cycle
  yt_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rd0   (rd0),
    .rd1   (rd1)
  );

  assign out_valid     = res.valid;
  assign out_value_out = res.value_out;
  assign out_found     = res.found;
  assign out_was_empty = res.was_empty;

  // A result beat always follows an accept or a busy cycle
  a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result beat without a command in flight");

  // Busy only rises on an accepted command
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // Empty extract returns the sentinel
  a_empty_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_empty) |-> (out_value_out == VALUE_W'(EMPTY_CELL)))
    else $error("was_empty set with non-sentinel value");

  // Search never reports alongside an extract flag
  a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (!out_was_empty && out_value_out == '0))
    else $error("found set on a non-search result");

endmodule

// ===== rtl/yt_store.sv =====
`timescale 1ns / 1ps

module yt_store (
  input  logic            clk,
  input  logic            rst_n,
  input  yt_pkg::st_req_t req,
  output yt_pkg::value_t  rd0,
  output yt_pkg::value_t  rd1
);
  import yt_pkg::*;

  value_t           mem [CELLS];
  logic [CELLS-1:0] valid_r;
  value_t           q0_r, q1_r;
  logic             v0_r, v1_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q0_r <= mem[req.raddr0];
    q1_r <= mem[req.raddr1];
  end

  // Per-entry valid: unwritten cells read as empty after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
      v0_r <= valid_r[req.raddr0];
      v1_r <= valid_r[req.raddr1];
    end
  end

  assign rd0 = v0_r ? q0_r : EMPTY_CELL;
  assign rd1 = v1_r ? q1_r : EMPTY_CELL;

endmodule

// ===== rtl/yt_ctrl.sv =====
`timescale 1ns / 1ps

module yt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [yt_pkg::ACT_W-1:0]    in_action,
  input  logic [yt_pkg::RC_W-1:0]     in_row,
  input  logic [yt_pkg::RC_W-1:0]     in_col,
  input  logic [yt_pkg::VALUE_W-1:0]  in_value,
  input  logic [yt_pkg::CFG_W-1:0]    rows_used,
  input  logic [yt_pkg::CFG_W-1:0]    cols_used,
  output logic                        busy,
  output yt_pkg::res_t                res,
  output yt_pkg::st_req_t             st_req,
  input  yt_pkg::value_t              rd0,
  input  yt_pkg::value_t              rd1
);
  import yt_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_X_RD  = 7'b0000010,
    ST_X_LD  = 7'b0000100,
    ST_S_RD  = 7'b0001000,
    ST_S_CMP = 7'b0010000,
    ST_Q_RD  = 7'b0100000,
    ST_Q_CMP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  dimr_t  r_r, r_nxt, i_r, i_nxt;
  dimc_t  c_r, c_nxt, j_r, j_nxt;
  value_t key_r, key_nxt;
  value_t cur_r, cur_nxt;
  value_t top_r, top_nxt;
  res_t   res_r, res_nxt;

  logic   accept;
  dimr_t  r_clamp;
  dimc_t  c_clamp;
  addr_t  here_addr, right_addr, down_addr, last_addr, srch_addr;
  logic   has_right, has_down, go_right;
  value_t pick;

  assign busy   = !state_r[0];
  assign accept = start && (state_r == ST_IDLE);
  assign res    = res_r;

  // Zero acts as one, oversize acts as full
  always_comb begin
    if (rows_used == '0) begin
      r_clamp = dimr_t'(1);
    end else if (int'(rows_used) > ROWS) begin
      r_clamp = dimr_t'(ROWS);
    end else begin
      r_clamp = dimr_t'(rows_used);
    end
    if (cols_used == '0) begin
      c_clamp = dimc_t'(1);
    end else if (int'(cols_used) > COLS) begin
      c_clamp = dimc_t'(COLS);
    end else begin
      c_clamp = dimc_t'(cols_used);
    end
  end

  assign here_addr  = cell_addr(row_t'(i_r), col_t'(j_r));
  assign right_addr = cell_addr(row_t'(i_r), col_t'(j_r + 1'b1));
  assign down_addr  = cell_addr(row_t'(i_r + 1'b1), col_t'(j_r));
  assign last_addr  = cell_addr(row_t'(r_r - 1'b1), col_t'(c_r - 1'b1));
  assign srch_addr  = cell_addr(row_t'(i_r - 1'b1), col_t'(j_r));

  assign has_right = (j_r + 1'b1) < c_r;
  assign has_down  = (i_r + 1'b1) < r_r;
  // tie goes right
  assign go_right  = has_right && (!has_down || (rd0 <= rd1));
  assign pick      = go_right ? rd0 : rd1;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    key_nxt   = key_r;
    cur_nxt   = cur_r;
    top_nxt   = top_r;
    res_nxt   = res_r;
    res_nxt.valid = 1'b0;
    st_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          r_nxt   = r_clamp;
          c_nxt   = c_clamp;
          key_nxt = value_t'(in_value);
          res_nxt = '0;
          priority if (in_action == ACT_WRITE) begin
            // write goes out at accept; result beat the next cycle
            if (int'(in_row) < ROWS && int'(in_col) < COLS) begin
              st_req.we    = 1'b1;
              st_req.waddr = cell_addr(row_t'(in_row), col_t'(in_col));
              st_req.wdata = value_t'(in_value);
            end
            res_nxt.valid = 1'b1;
          end else if (in_action == ACT_EXTRACT) begin
            state_nxt = ST_X_RD;
          end else if (in_action == ACT_SEARCH) begin
            i_nxt     = r_clamp;
            j_nxt     = '0;
            state_nxt = ST_Q_RD;
          end else begin
            res_nxt.valid = 1'b1;
          end
        end
      end

      ST_X_RD: begin
        st_req.raddr0 = '0;
        st_req.raddr1 = last_addr;
        state_nxt     = ST_X_LD;
      end

      ST_X_LD: begin
        top_nxt      = rd0;
        cur_nxt      = (last_addr == '0) ? EMPTY_CELL : rd1;
        st_req.we    = 1'b1;
        st_req.waddr = last_addr;
        st_req.wdata = EMPTY_CELL;
        i_nxt        = '0;
        j_nxt        = '0;
        state_nxt    = ST_S_RD;
      end

      ST_S_RD: begin
        if (!has_right && !has_down) begin
          st_req.we         = 1'b1;
          st_req.waddr      = here_addr;
          st_req.wdata      = cur_r;
          res_nxt.valid     = 1'b1;
          res_nxt.value_out = VALUE_W'(top_r);
          res_nxt.was_empty = (top_r == EMPTY_CELL);
          state_nxt         = ST_IDLE;
        end else begin
          st_req.raddr0 = right_addr;
          st_req.raddr1 = down_addr;
          state_nxt     = ST_S_CMP;
        end
      end

      ST_S_CMP: begin
        st_req.we    = 1'b1;
        st_req.waddr = here_addr;
        if (pick < cur_r) begin
          // neighbor moves up, current value moves on
          st_req.wdata = pick;
          if (go_right) begin
            j_nxt = j_r + 1'b1;
          end else begin
            i_nxt = i_r + 1'b1;
          end
          state_nxt = ST_S_RD;
        end else begin
          st_req.wdata      = cur_r;
          res_nxt.valid     = 1'b1;
          res_nxt.value_out = VALUE_W'(top_r);
          res_nxt.was_empty = (top_r == EMPTY_CELL);
          state_nxt         = ST_IDLE;
        end
      end

      ST_Q_RD: begin
        if (i_r == '0 || j_r >= c_r) begin
          res_nxt.valid = 1'b1;
          res_nxt.found = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          st_req.raddr0 = srch_addr;
          state_nxt     = ST_Q_CMP;
        end
      end

      ST_Q_CMP: begin
        if (rd0 == key_r) begin
          res_nxt.valid = 1'b1;
          res_nxt.found = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          if (rd0 > key_r) begin
            i_nxt = i_r - 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          state_nxt = ST_Q_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    key_r <= key_nxt;
    cur_r <= cur_nxt;
    top_r <= top_nxt;
  end

endmodule

// ===== bench/young_tableau_extract_and_search_tb.sv =====
`timescale 1ns / 1ps

module young_tableau_extract_and_search_tb;
  import yt_pkg::*;

  // Action 3 is not decoded by the block; it must come back as an all-zero beat.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int IDLE_LIMIT    = 2000;  // cycles with no accept and no result beat
  localparam int SETTLE_CYCLES = 20;    // more than the longest command takes
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [VALUE_W-1:0] value_out;
    logic               found;
    logic               was_empty;
  } tableau_result_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic [ACT_W-1:0]     in_action = '0;
  logic [RC_W-1:0]      in_row    = '0;
  logic [RC_W-1:0]      in_col    = '0;
  logic [VALUE_W-1:0]   in_value  = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 busy;
  logic                 out_valid;
  logic [VALUE_W-1:0]   out_value_out;
  logic                 out_found;
  logic                 out_was_empty;

  young_tableau_extract_and_search u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_value_out(out_value_out),
    .out_found    (out_found),
    .out_was_empty(out_was_empty),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow tableau: the predictor keeps its own copy of the cell store, updated
  // at the accept edge of each command, and of the two size registers.
  // ---------------------------------------------------------------------------
  value_t           shadow_cells [CELLS];
  logic [CFG_W-1:0] shadow_rows;
  logic [CFG_W-1:0] shadow_cols;

  tableau_result_t  pending_results [$];   // predicted beats, oldest first
  tableau_result_t  expected_beat;
  int               mismatches  = 0;
  int               idle_cycles = 0;
  bit               no_gaps     = 1'b0;    // burst mode: sender never idles

  // Register value 0 acts as 1, anything past the store size clamps to it.
  function automatic int used_dim(logic [CFG_W-1:0] dim_reg, int lim);
    if (dim_reg == '0) return 1;
    if (int'(dim_reg) > lim) return lim;
    return int'(dim_reg);
  endfunction

  // Push the corner value down; tie between neighbors goes right, and a swap
  // happens only on a strictly smaller neighbor.
  function automatic void sift_corner(int r, int c);
    int     i;
    int     j;
    int     here;
    int     pick;
    bit     go_right;
    value_t t;
    i = 0;
    j = 0;
    while (1'b1) begin
      here = i * COLS + j;
      if (j + 1 < c && i + 1 < r) begin
        go_right = shadow_cells[here + 1] <= shadow_cells[here + COLS];
      end else if (j + 1 < c) begin
        go_right = 1'b1;
      end else if (i + 1 < r) begin
        go_right = 1'b0;
      end else begin
        return;
      end
      pick = go_right ? here + 1 : here + COLS;
      if (!(shadow_cells[pick] < shadow_cells[here])) return;
      t                  = shadow_cells[here];
      shadow_cells[here] = shadow_cells[pick];
      shadow_cells[pick] = t;
      if (go_right) j++;
      else i++;
    end
  endfunction

  // Staircase walk from the bottom-left used cell.
  function automatic bit key_present(value_t key, int r, int c);
    int     i;
    int     j;
    value_t v;
    i = r;
    j = 0;
    while (i > 0 && j < c) begin
      v = shadow_cells[(i - 1) * COLS + j];
      if (v == key) return 1'b1;
      if (v > key) i--;
      else j++;
    end
    return 1'b0;
  endfunction

  function automatic tableau_result_t apply_command(logic [ACT_W-1:0] action,
                                                    logic [RC_W-1:0] row,
                                                    logic [RC_W-1:0] col,
                                                    logic [VALUE_W-1:0] value);
    tableau_result_t res;
    int              r;
    int              c;
    int              last;
    value_t          top;
    res.value_out = '0;
    res.found     = 1'b0;
    res.was_empty = 1'b0;
    r = used_dim(shadow_rows, ROWS);
    c = used_dim(shadow_cols, COLS);
    case (action)
      ACT_WRITE: begin
        // 2-bit row/col always land inside the 4x4 store, used region or not
        shadow_cells[int'(row) * COLS + int'(col)] = value_t'(value);
      end
      ACT_EXTRACT: begin
        last               = (r - 1) * COLS + (c - 1);
        top                = shadow_cells[0];
        shadow_cells[0]    = shadow_cells[last];
        shadow_cells[last] = EMPTY_CELL;
        sift_corner(r, c);
        res.value_out = VALUE_W'(top);
        res.was_empty = (top == EMPTY_CELL);
      end
      ACT_SEARCH: begin
        res.found = key_present(value_t'(value), r, c);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. The block cannot be stalled, so every out_valid cycle is a
  // beat that must match the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, longint unsigned exp_v, longint unsigned act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result beat (value_out)", 0, out_value_out);
      end else begin
        expected_beat = pending_results.pop_front();
        if (out_value_out !== expected_beat.value_out)
          note_mismatch("value_out", expected_beat.value_out, out_value_out);
        if (out_found !== expected_beat.found)
          note_mismatch("found", expected_beat.found, out_found);
        if (out_was_empty !== expected_beat.was_empty)
          note_mismatch("was_empty", expected_beat.was_empty, out_was_empty);
      end
    end
  end

  // Watchdog: any accept or result beat resets the count.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Issue one command beat. start is left high on return, so the caller must
  // send again in the same step or lower it (wait_idle does).
  task automatic send_command(logic [ACT_W-1:0] action, logic [RC_W-1:0] row,
                              logic [RC_W-1:0] col, logic [VALUE_W-1:0] value);
    int gap;
    if ($urandom_range(0, 39) == 0) no_gaps = ~no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= action;
    in_row    <= row;
    in_col    <= col;
    in_value  <= value;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_command(action, row, col, value));
  endtask

  // Drop start, let every predicted beat come back, then allow the block to
  // settle for the longest command latency.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Size registers are only written with the block idle.
  task automatic set_dims(logic [CFG_W-1:0] rows_val, logic [CFG_W-1:0] cols_val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_USED;
    cfg_data  <= rows_val;
    @(posedge clk);
    shadow_rows = rows_val;
    cfg_index <= CFG_COLS_USED;
    cfg_data  <= cols_val;
    @(posedge clk);
    shadow_cols = cols_val;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RC_W-1:0] any_rc();
    return RC_W'($urandom_range(0, 3));
  endfunction

  // Load the used region with a valid tableau: each cell is at least its upper
  // and left neighbors, cells above a random ceiling stay empty. Writes go out
  // in shuffled order.
  task automatic load_sorted_tableau();
    int          r;
    int          c;
    int          step_max;
    int          ceiling;
    int          prev;
    int          k;
    int          swap_at;
    int          tmp;
    int          grid  [CELLS];
    int          order [CELLS];
    r        = used_dim(shadow_rows, ROWS);
    c        = used_dim(shadow_cols, COLS);
    step_max = $urandom_range(0, 1) ? 3 : 60000;  // small steps give ties
    for (int i = 0; i < r; i++) begin
      for (int j = 0; j < c; j++) begin
        if (i == 0 && j == 0) prev = $urandom_range(0, 1000);
        else if (i == 0) prev = grid[j - 1];
        else if (j == 0) prev = grid[(i - 1) * COLS];
        else prev = (grid[(i - 1) * COLS + j] > grid[i * COLS + j - 1]) ?
                    grid[(i - 1) * COLS + j] : grid[i * COLS + j - 1];
        grid[i * COLS + j] = prev + $urandom_range(0, step_max);
      end
    end
    ceiling = ($urandom_range(0, 2) == 0) ? int'(EMPTY_CELL) :
              $urandom_range(0, grid[(r - 1) * COLS + c - 1]);
    for (k = 0; k < r * c; k++) order[k] = k;
    for (k = r * c - 1; k > 0; k--) begin
      swap_at        = $urandom_range(0, k);
      tmp            = order[k];
      order[k]       = order[swap_at];
      order[swap_at] = tmp;
    end
    for (k = 0; k < r * c; k++) begin
      tmp = (order[k] / c) * COLS + (order[k] % c);
      send_command(ACT_WRITE, RC_W'(order[k] / c), RC_W'(order[k] % c),
                   (grid[tmp] > ceiling) ? VALUE_W'(EMPTY_CELL) : VALUE_W'(grid[tmp]));
    end
  endtask

  // Search key: a stored cell, its near miss, a random value or an extreme.
  function automatic logic [VALUE_W-1:0] pick_search_key();
    int     r;
    int     c;
    value_t v;
    r = used_dim(shadow_rows, ROWS);
    c = used_dim(shadow_cols, COLS);
    v = shadow_cells[$urandom_range(0, r - 1) * COLS + $urandom_range(0, c - 1)];
    case ($urandom_range(0, 3))
      0: return VALUE_W'(v);
      1: begin
        if (v == EMPTY_CELL || (v != 0 && $urandom_range(0, 1))) return VALUE_W'(v - 1);
        return VALUE_W'(v + 1);
      end
      2: return VALUE_W'($urandom_range(0, 1000000));
      default: return $urandom_range(0, 1) ? VALUE_W'(EMPTY_CELL) : '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked cases: empty store after reset, tie in sift-down, unused
  // action, writes outside the used region, and out-of-range size registers.
  task automatic test_directed();
    // store is all empty right after reset
    send_command(ACT_EXTRACT, any_rc(), any_rc(), VALUE_W'(EMPTY_CELL));
    send_command(ACT_SEARCH, any_rc(), any_rc(), VALUE_W'(EMPTY_CELL));
    send_command(ACT_SEARCH, any_rc(), any_rc(), '0);
    set_dims(3'd4, 3'd4);
    // equal right and lower neighbors: sift must go right
    send_command(ACT_WRITE, 2'd0, 2'd0, '0);
    send_command(ACT_WRITE, 2'd0, 2'd1, VALUE_W'(7));
    send_command(ACT_WRITE, 2'd1, 2'd0, VALUE_W'(7));
    send_command(ACT_EXTRACT, 2'd3, 2'd3, '1);
    send_command(ACT_SEARCH, 2'd0, 2'd0, VALUE_W'(7));
    send_command(ACT_SEARCH, 2'd0, 2'd0, VALUE_W'(8));
    // undecoded action with every input bit high, then low
    send_command(ACT_UNUSED, 2'd3, 2'd3, '1);
    send_command(ACT_UNUSED, 2'd0, 2'd0, '0);
    // 0 rows -> 1 row, 7 cols -> 4 cols
    set_dims(3'd0, 3'd7);
    send_command(ACT_WRITE, 2'd3, 2'd3, VALUE_W'(999999));  // outside used region
    send_command(ACT_WRITE, 2'd0, 2'd3, VALUE_W'(3));
    send_command(ACT_EXTRACT, 2'd1, 2'd2, '0);
    send_command(ACT_SEARCH, 2'd0, 2'd0, VALUE_W'(999999));
    // 7 rows -> 4 rows, 0 cols -> 1 col
    set_dims(3'd7, 3'd0);
    send_command(ACT_EXTRACT, 2'd2, 2'd1, '0);
    send_command(ACT_SEARCH, 2'd3, 2'd0, VALUE_W'(7));
    // single cell
    set_dims(3'd1, 3'd1);
    send_command(ACT_WRITE, 2'd0, 2'd0, VALUE_W'(42));
    send_command(ACT_EXTRACT, 2'd0, 2'd0, '0);
    send_command(ACT_EXTRACT, 2'd0, 2'd0, '0);
  endtask

  // Mostly well-formed use: load a sorted tableau, then extract and search,
  // with an occasional stray write mixed in.
  task automatic test_sorted_tableaux();
    int n_ops;
    int pick;
    for (int round = 0; round < 14; round++) begin
      case (round)
        0:       set_dims(3'd4, 3'd4);
        1:       set_dims(3'd1, 3'd1);
        2:       set_dims(3'd1, 3'd4);
        3:       set_dims(3'd4, 3'd1);
        default: set_dims(CFG_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 7)));
      endcase
      load_sorted_tableau();
      n_ops = $urandom_range(20, 35);
      for (int k = 0; k < n_ops; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          send_command(ACT_EXTRACT, any_rc(), any_rc(), VALUE_W'($urandom_range(0, 1000000)));
        else if (pick < 95)
          send_command(ACT_SEARCH, any_rc(), any_rc(), pick_search_key());
        else
          send_command(ACT_WRITE, any_rc(), any_rc(), VALUE_W'($urandom_range(0, 1000000)));
      end
    end
  endtask

  // Unstructured commands, all four action codes, any sizes.
  task automatic test_noise();
    logic [VALUE_W-1:0] v;
    for (int k = 0; k < 380; k++) begin
      if (k % 50 == 0)
        set_dims(CFG_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 7)));
      case ($urandom_range(0, 7))
        0:       v = VALUE_W'(EMPTY_CELL);
        1:       v = '0;
        default: v = VALUE_W'($urandom_range(0, 1000000));
      endcase
      send_command(ACT_W'($urandom_range(0, 3)), any_rc(), any_rc(), v);
    end
  endtask

  initial begin
    foreach (shadow_cells[k]) shadow_cells[k] = EMPTY_CELL;
    shadow_rows = CFG_W'(4);
    shadow_cols = CFG_W'(4);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_sorted_tableaux();
    test_noise();
    wait_idle();

    // leftover predictions mean beats never arrived
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/yt_pkg.sv
rtl/yt_store.sv
rtl/yt_ctrl.sv
rtl/young_tableau_extract_and_search.sv
bench/young_tableau_extract_and_search_tb.sv
